@@ sv/aup_pkg.sv @@
// aup_pkg: shared types, constants and step functions of the adam parameter update block
// depends on nothing; used by every module of the block
package aup_pkg;

	localparam int ELEMENT_COUNT = 1024;
	localparam int ADDR_W = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

	// divider and square root pipelines, steps per register stage
	localparam int DIV_BITS = 64;
	localparam int DIV_STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES = DIV_BITS / DIV_STEPS_PER_STAGE;
	localparam int SQRT_BITS = 32;
	localparam int SQRT_STEPS_PER_STAGE = 2;
	localparam int SQRT_STAGES = SQRT_BITS / SQRT_STEPS_PER_STAGE;

	// register indexes
	localparam logic [1:0] REG_STEP_SIZE    = 2'd0;
	localparam logic [1:0] REG_FIRST_DECAY  = 2'd1;
	localparam logic [1:0] REG_SECOND_DECAY = 2'd2;
	localparam logic [1:0] REG_STABILIZER   = 2'd3;

	// action codes
	localparam logic ACT_UPDATE  = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOSTEP = 2'd1;
	localparam logic [1:0] ST_SAT    = 2'd2;

	typedef struct packed {
		logic        action;
		logic [9:0]  element_index;
		logic [31:0] gradient;
		logic [31:0] current_value;
	} aup_in_t;

	typedef struct packed {
		logic [9:0]  result_index;
		logic [31:0] new_value;
		logic [1:0]  status;
	} aup_out_t;

	// moment store access of the item in the first stage
	typedef struct packed {
		logic        wr;
		logic [9:0]  idx;
		logic [31:0] grad;
		logic [31:0] g2;
	} aup_mom_req_t;

	// what travels alongside the arithmetic of an item
	typedef struct packed {
		logic        valid;
		logic        bypass;
		logic [1:0]  stat_pre;
		logic [9:0]  idx;
		logic [31:0] value;
		logic        g2sat;
		logic        neg;
		logic        mz;
		logic [55:0] pp_lo;
		logic [55:0] pp_hi;
	} aup_side_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] lo;
		logic [63:0] d;
		logic [63:0] q;
		logic        sat;
	} aup_div_st_t;

	typedef struct packed {
		logic [63:0] x;
		logic [34:0] rem;
		logic [31:0] root;
	} aup_sqrt_st_t;

	// one restoring division step, dividend bits taken from the top of lo
	function automatic aup_div_st_t div_step(input aup_div_st_t s);
		aup_div_st_t n;
		logic [63:0] r;
		n = s;
		r = {s.rem[62:0], s.lo[63]};
		n.lo = {s.lo[62:0], 1'b0};
		if (s.rem[63] || (r >= s.d)) begin
			n.rem = r - s.d;
			n.q = {s.q[62:0], 1'b1};
		end else begin
			n.rem = r;
			n.q = {s.q[62:0], 1'b0};
		end
		return n;
	endfunction

	// one digit of the integer square root, two radicand bits a step
	function automatic aup_sqrt_st_t sqrt_step(input aup_sqrt_st_t s);
		aup_sqrt_st_t n;
		logic [34:0] r;
		logic [34:0] t;
		n = s;
		r = {s.rem[32:0], s.x[63:62]};
		t = {1'b0, s.root, 2'b01};
		n.x = {s.x[61:0], 2'b00};
		if (r >= t) begin
			n.rem = r - t;
			n.root = {s.root[30:0], 1'b1};
		end else begin
			n.rem = r;
			n.root = {s.root[30:0], 1'b0};
		end
		return n;
	endfunction

endpackage

@@ sv/aup_moment.sv @@
// aup_moment: first and second moment stores with clearing pass, forwarding and moment update
// depends on aup_pkg
module aup_moment import aup_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [9:0]   rd_idx,
	input  aup_mom_req_t req,
	input  logic [23:0]  first_decay,
	input  logic [23:0]  second_decay,
	output logic [31:0]  m_s2,
	output logic [31:0]  v_s2,
	output logic         busy
);

	logic [31:0] mem_m [0:ELEMENT_COUNT-1];
	logic [31:0] mem_v [0:ELEMENT_COUNT-1];
	logic [31:0] rd_m_q, rd_v_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic busy_q;
	logic wr_s2;
	logic [9:0] idx_s2;

	logic fwd_hit;
	logic [31:0] m_old, v_old, m_new, v_new;
	logic signed [32:0] m_diff, v_diff;
	logic signed [57:0] m_prod, v_prod;
	logic signed [58:0] m_sum, v_sum;
	logic we;
	logic [ADDR_W-1:0] waddr;
	logic [31:0] wm, wv;

	assign busy = busy_q;

	// item written last edge is not yet in the read data
	assign fwd_hit = wr_s2 && (idx_s2 == req.idx);
	assign m_old = fwd_hit ? m_s2 : rd_m_q;
	assign v_old = fwd_hit ? v_s2 : rd_v_q;

	// b*old + (1-b)*new as new*2^24 + b*(old-new), floor shift
	assign m_diff = $signed({m_old[31], m_old}) - $signed({req.grad[31], req.grad});
	assign m_prod = $signed({1'b0, first_decay}) * m_diff;
	assign m_sum = $signed({{3{req.grad[31]}}, req.grad, 24'd0}) + 59'(m_prod);
	assign m_new = m_sum[55:24];

	assign v_diff = $signed({1'b0, v_old}) - $signed({1'b0, req.g2});
	assign v_prod = $signed({1'b0, second_decay}) * v_diff;
	assign v_sum = $signed({3'd0, req.g2, 24'd0}) + 59'(v_prod);
	assign v_new = v_sum[55:24];

	assign we = busy_q || (en && req.wr);
	assign waddr = busy_q ? clr_addr_q : ADDR_W'(req.idx);
	assign wm = busy_q ? 32'd0 : m_new;
	assign wv = busy_q ? 32'd0 : v_new;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_m[waddr] <= wm;
			mem_v[waddr] <= wv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_m_q <= mem_m[ADDR_W'(rd_idx)];
			rd_v_q <= mem_v[ADDR_W'(rd_idx)];
			m_s2 <= m_new;
			v_s2 <= v_new;
			idx_s2 <= req.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_addr_q <= '0;
			wr_s2 <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(ELEMENT_COUNT - 1)) begin
					busy_q <= 1'b0;
				end
			end
			if (en) begin
				wr_s2 <= req.wr;
			end
		end
	end

endmodule

@@ sv/aup_div.sv @@
// aup_div: pipelined 128 by 64 bit restoring divider, quotient saturated to 64 bits
// depends on aup_pkg
module aup_div import aup_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [63:0] hi,
	input  logic [63:0] lo,
	input  logic [63:0] dv,
	input  aup_side_t   side_i,
	output logic [63:0] quo,
	output aup_side_t   side_o
);

	aup_div_st_t st_s [0:DIV_STAGES];
	aup_side_t sd_s [0:DIV_STAGES];
	aup_div_st_t nxt [1:DIV_STAGES];

	always_comb begin
		for (int k = 1; k <= DIV_STAGES; k++) begin
			nxt[k] = st_s[k-1];
			for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
				nxt[k] = div_step(nxt[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].rem <= hi;
			st_s[0].lo <= lo;
			st_s[0].d <= dv;
			st_s[0].q <= '0;
			st_s[0].sat <= (hi >= dv);
			for (int k = 1; k <= DIV_STAGES; k++) begin
				st_s[k] <= nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) begin
				sd_s[k] <= '0;
			end
		end else if (en) begin
			sd_s[0] <= side_i;
			for (int k = 1; k <= DIV_STAGES; k++) begin
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	assign quo = st_s[DIV_STAGES].sat ? '1 : st_s[DIV_STAGES].q;
	assign side_o = sd_s[DIV_STAGES];

endmodule

@@ sv/aup_sqrt.sv @@
// aup_sqrt: pipelined integer square root of a 64 bit radicand
// depends on aup_pkg
module aup_sqrt import aup_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [63:0] radicand,
	input  aup_side_t   side_i,
	output logic [31:0] root,
	output aup_side_t   side_o
);

	aup_sqrt_st_t st_s [0:SQRT_STAGES];
	aup_side_t sd_s [0:SQRT_STAGES];
	aup_sqrt_st_t nxt [1:SQRT_STAGES];

	always_comb begin
		for (int k = 1; k <= SQRT_STAGES; k++) begin
			nxt[k] = st_s[k-1];
			for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
				nxt[k] = sqrt_step(nxt[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].x <= radicand;
			st_s[0].rem <= '0;
			st_s[0].root <= '0;
			for (int k = 1; k <= SQRT_STAGES; k++) begin
				st_s[k] <= nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SQRT_STAGES; k++) begin
				sd_s[k] <= '0;
			end
		end else if (en) begin
			sd_s[0] <= side_i;
			for (int k = 1; k <= SQRT_STAGES; k++) begin
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	assign root = st_s[SQRT_STAGES].root;
	assign side_o = sd_s[SQRT_STAGES];

endmodule

@@ sv/adam_parameter_update.sv @@
// adam_parameter_update: top level, input stage, decay powers, configuration and result buffer
// depends on aup_pkg, aup_moment, aup_div, aup_sqrt
//
// Adam update of one Q16.16 parameter element per item. An update item (action 0) returns
// one result; an advance item (action 1) bumps the timestep and the decay powers and returns
// nothing. Items enter at one per cycle while upd_stall is low, and results leave in order.
// The two 64 bit dividers for m_hat and v_hat run side by side, then come the square
// root and the final 64 bit divider, each resolving two bits per stage (33 + 17 + 33 stages),
// plus the moment read, moment update and result stages.
// The moment stores sit in two RAMs of ELEMENT_COUNT words with one read and one write port;
// right after reset a clearing pass zeroes them, and upd_stall stays high during it. A two
// entry result buffer lets the pipeline keep taking items while one result waits.
// Configuration writes are always ready and are meant for an idle block.
module adam_parameter_update import aup_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd_valid,
	output logic        upd_stall,
	input  aup_in_t     upd_item,
	output logic        res_valid,
	input  logic        res_stall,
	output aup_out_t    res_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration registers
	logic [23:0] step_size_q, first_decay_q, second_decay_q;
	logic [31:0] stabilizer_q;

	// running decay powers, Q1.32, and timestep count
	logic [32:0] pow1_q, pow2_q;
	logic [31:0] tstep_q;

	// pipeline advance, held only when the result buffer is full
	logic en, busy, accept;

	// stage 1: captured item, squared gradient, bias correction factors
	logic vld_s1, byp_s1, g2sat_s1;
	logic [1:0] stat_s1;
	logic [9:0] idx_s1;
	logic [31:0] val_s1, grad_s1, g2_s1;
	logic [32:0] c1_s1, c2_s1;

	// stage 2: new moments come out of the moment block
	aup_side_t side_s2;
	logic [32:0] c1_s2, c2_s2;
	logic [31:0] m_s2, v_s2;

	aup_mom_req_t req;
	logic [31:0] gmag, mmag;
	logic [63:0] gsq;
	logic [32:0] c1_in, c2_in;
	logic in_range;

	// divider and root stage signals
	logic [63:0] mhat, vhat, vcap, den, delta_q;
	logic [87:0] prod;
	logic [31:0] root;
	aup_side_t side_m, side_p, side_r, side_f;

	// final stage
	aup_side_t side_o;
	logic [33:0] delta;
	logic signed [34:0] vs, res;
	logic res_sat;
	aup_out_t fin;

	// result buffer
	aup_out_t buf_q [0:1];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign cfg_ready = 1'b1;
	assign en = (cnt_q != 2'd2);
	assign upd_stall = !en || busy;
	assign accept = upd_valid && !upd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= 24'd16777;
			first_decay_q <= 24'd15099494;
			second_decay_q <= 24'd16760439;
			stabilizer_q <= 32'd43;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEP_SIZE: begin
					step_size_q <= cfg_data[23:0];
				end
				REG_FIRST_DECAY: begin
					first_decay_q <= cfg_data[23:0];
				end
				REG_SECOND_DECAY: begin
					second_decay_q <= cfg_data[23:0];
				end
				REG_STABILIZER: begin
					stabilizer_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// advance item: power = power * decay >> 24, timestep saturates at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pow1_q <= 33'h1_0000_0000;
			pow2_q <= 33'h1_0000_0000;
			tstep_q <= '0;
		end else if (accept && (upd_item.action == ACT_ADVANCE)) begin
			pow1_q <= 33'((57'(pow1_q) * 57'(first_decay_q)) >> 24);
			pow2_q <= 33'((57'(pow2_q) * 57'(second_decay_q)) >> 24);
			if (tstep_q != '1) begin
				tstep_q <= tstep_q + 32'd1;
			end
		end
	end

	// squared gradient magnitude, Q16.16, clamped to 32 bits
	assign gmag = upd_item.gradient[31] ? (~upd_item.gradient + 32'd1) : upd_item.gradient;
	assign gsq = 64'(gmag) * 64'(gmag);

	// correction factors 1 - beta^t, a zero factor replaced by one LSB (raw value 1)
	assign c1_in = (pow1_q == 33'h1_0000_0000) ? 33'd1 : (33'h1_0000_0000 - pow1_q);
	assign c2_in = (pow2_q == 33'h1_0000_0000) ? 33'd1 : (33'h1_0000_0000 - pow2_q);
	assign in_range = (32'(upd_item.element_index) < 32'(ELEMENT_COUNT));

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= upd_item.element_index;
			val_s1 <= upd_item.current_value;
			grad_s1 <= upd_item.gradient;
			g2_s1 <= (gsq[63:48] != 16'd0) ? 32'hFFFF_FFFF : gsq[47:16];
			g2sat_s1 <= (gsq[63:48] != 16'd0);
			c1_s1 <= c1_in;
			c2_s1 <= c2_in;
			// out of range or no timestep yet: value passes unchanged
			byp_s1 <= !in_range || (tstep_q == '0);
			stat_s1 <= (in_range && (tstep_q == '0)) ? ST_NOSTEP : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept && (upd_item.action == ACT_UPDATE);
		end
	end

	assign req.wr = vld_s1 && !byp_s1;
	assign req.idx = idx_s1;
	assign req.grad = grad_s1;
	assign req.g2 = g2_s1;

	aup_moment u_moment (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.rd_idx       (upd_item.element_index),
		.req          (req),
		.first_decay  (first_decay_q),
		.second_decay (second_decay_q),
		.m_s2         (m_s2),
		.v_s2         (v_s2),
		.busy         (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (en) begin
			side_s2.valid <= vld_s1;
			side_s2.bypass <= byp_s1;
			side_s2.stat_pre <= stat_s1;
			side_s2.idx <= idx_s1;
			side_s2.value <= val_s1;
			side_s2.g2sat <= g2sat_s1;
			side_s2.neg <= 1'b0;
			side_s2.mz <= 1'b0;
			side_s2.pp_lo <= '0;
			side_s2.pp_hi <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c1_s2 <= c1_s1;
			c2_s2 <= c2_s1;
		end
	end

	// sign of m rides along, the dividers see its magnitude
	assign mmag = m_s2[31] ? (~m_s2 + 32'd1) : m_s2;

	always_comb begin
		side_m = side_s2;
		side_m.neg = m_s2[31];
	end

	// m_hat = |m| * 2^32 / c1
	aup_div u_div_m (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.hi     (64'd0),
		.lo     ({mmag, 32'd0}),
		.dv     (64'(c1_s2)),
		.side_i (side_m),
		.quo    (mhat),
		.side_o (side_p)
	);

	// v_hat = v * 2^32 / c2
	aup_div u_div_v (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.hi     (64'd0),
		.lo     ({v_s2, 32'd0}),
		.dv     (64'(c2_s2)),
		.side_i (side_m),
		.quo    (vhat),
		.side_o ()
	);

	// cap v_hat below 2^56 and split alpha * m_hat into two partial products
	assign vcap = (vhat > 64'h00FF_FFFF_FFFF_FFFF) ? 64'h00FF_FFFF_FFFF_FFFF : vhat;

	always_comb begin
		side_r = side_p;
		side_r.mz = (mhat == 64'd0) || (step_size_q == 24'd0);
		side_r.pp_lo = 56'(step_size_q) * 56'(mhat[31:0]);
		side_r.pp_hi = 56'(step_size_q) * 56'(mhat[63:32]);
	end

	aup_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.radicand ({vcap[55:0], 8'd0}),
		.side_i   (side_r),
		.root     (root),
		.side_o   (side_f)
	);

	// den = root * 2^20 + epsilon; dividend = alpha * m_hat * 2^8
	assign den = {12'd0, root, 20'd0} + 64'(stabilizer_q);
	assign prod = {side_f.pp_hi, 32'd0} + 88'(side_f.pp_lo);

	aup_div u_div_d (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.hi     (64'(prod[87:56])),
		.lo     ({prod[55:0], 8'd0}),
		.dv     (den),
		.side_i (side_f),
		.quo    (delta_q),
		.side_o (side_o)
	);

	// delta clamped to 2^33, then moved against the sign of m and saturated
	always_comb begin
		if (side_o.mz) begin
			delta = 34'd0;
		end else if (delta_q > 64'h2_0000_0000) begin
			delta = 34'h2_0000_0000;
		end else begin
			delta = delta_q[33:0];
		end
		vs = $signed({{3{side_o.value[31]}}, side_o.value});
		res = side_o.neg ? (vs + $signed({1'b0, delta})) : (vs - $signed({1'b0, delta}));
		res_sat = 1'b0;
		fin.result_index = side_o.idx;
		if (res > 35'sd2147483647) begin
			res_sat = 1'b1;
			fin.new_value = 32'h7FFF_FFFF;
		end else if (res < -35'sd2147483648) begin
			res_sat = 1'b1;
			fin.new_value = 32'h8000_0000;
		end else begin
			fin.new_value = res[31:0];
		end
		fin.status = (res_sat || side_o.g2sat) ? ST_SAT : ST_OK;
		if (side_o.bypass) begin
			fin.new_value = side_o.value;
			fin.status = side_o.stat_pre;
		end
	end

	// two entry result buffer
	assign push = en && side_o.valid;
	assign pop = res_valid && !res_stall;
	assign res_valid = (cnt_q != 2'd0);
	assign res_item = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ sv/aup_checker.sv @@
// aup_checker: port level checks of adam_parameter_update, bound to the top level
// depends on aup_pkg and adam_parameter_update
module aup_checker import aup_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        upd_valid,
	input logic        upd_stall,
	input aup_in_t     upd_item,
	input logic        res_valid,
	input logic        res_stall,
	input aup_out_t    res_item,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [31:0] cfg_data
);

	// update items taken but not yet delivered
	logic [7:0] pend_q;
	logic take, give;

	assign take = upd_valid && !upd_stall && (upd_item.action == ACT_UPDATE);
	assign give = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {7'd0, take} - {7'd0, give};
		end
	end

	// a stalled item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result item changed");

	// a stalled input item holds
	a_upd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		upd_valid && upd_stall |=> upd_valid && $stable(upd_item))
		else $error("stalled input item changed");

	// no item delivered without an update item before it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		give |-> (pend_q != 8'd0))
		else $error("result item without pending update item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.status == ST_OK || res_item.status == ST_NOSTEP ||
			res_item.status == ST_SAT))
		else $error("result status out of range");

	// register writes land only on an idle block, with known index and data
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> (pend_q == 8'd0) && !res_valid &&
			!$isunknown({cfg_index, cfg_data}))
		else $error("configuration write while items in flight");

endmodule

bind adam_parameter_update aup_checker u_aup_checker (.*);
